[rtl/core/cpp_pkg.sv]
// shared types and constants of the camera point projector
package cpp_pkg;

    localparam int CAM_W  = 40;
    localparam int DIV_N  = 26;
    localparam int REM_W  = CAM_W + 1;

    localparam logic [2:0] CFG_ROT_X  = 3'd0;
    localparam logic [2:0] CFG_ROT_Y  = 3'd1;
    localparam logic [2:0] CFG_ROT_Z  = 3'd2;
    localparam logic [2:0] CFG_TRANS  = 3'd3;
    localparam logic [2:0] CFG_INTR_0 = 3'd4;
    localparam logic [2:0] CFG_INTR_1 = 3'd5;
    localparam logic [2:0] CFG_RADIAL = 3'd6;

    typedef struct packed {
        logic [CAM_W-1:0] den;
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [DIV_N-1:0] sh_x;
        logic [DIV_N-1:0] sh_y;
        logic [DIV_N-1:0] q_x;
        logic [DIV_N-1:0] q_y;
        logic             neg_x;
        logic             neg_y;
        logic             sat_x;
        logic             sat_y;
        logic             behind;
    } t_div;

endpackage

[rtl/core/cpp_div_stage.sv]
// one restoring division step for both normalized coordinates
module cpp_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cpp_pkg::t_div i_d,
    output logic          o_valid,
    output cpp_pkg::t_div o_d
);

    logic [cpp_pkg::REM_W-1:0] n_tx, n_ty;
    logic                      n_bx, n_by;
    cpp_pkg::t_div             n_d;
    logic                      r_valid;
    cpp_pkg::t_div             r_d;

    always_comb begin
        n_tx = {i_d.rem_x[cpp_pkg::REM_W-2:0], i_d.sh_x[cpp_pkg::DIV_N-1]};
        n_ty = {i_d.rem_y[cpp_pkg::REM_W-2:0], i_d.sh_y[cpp_pkg::DIV_N-1]};
        n_bx = (n_tx >= {1'b0, i_d.den});
        n_by = (n_ty >= {1'b0, i_d.den});
        n_d       = i_d;
        n_d.rem_x = n_bx ? n_tx - {1'b0, i_d.den} : n_tx;
        n_d.rem_y = n_by ? n_ty - {1'b0, i_d.den} : n_ty;
        n_d.sh_x  = {i_d.sh_x[cpp_pkg::DIV_N-2:0], 1'b0};
        n_d.sh_y  = {i_d.sh_y[cpp_pkg::DIV_N-2:0], 1'b0};
        n_d.q_x   = {i_d.q_x[cpp_pkg::DIV_N-2:0], n_bx};
        n_d.q_y   = {i_d.q_y[cpp_pkg::DIV_N-2:0], n_by};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

[rtl/core/camera_point_projection.sv]
// pipelined pinhole projector with two-term radial distortion
//
//  channel | signals                                   | dir
//  config  | i_cfg_we i_cfg_idx i_cfg_data             | in
//  point   | i_in_valid o_in_ready i_point_x/y/z       | in
//  pixel   | o_out_valid i_out_ready o_pixel_u/v flags | out
//
// one word accepted per cycle while the output skid is empty; the depth divide
// is a 26-step restoring divider, one step per stage
// synchronous active-low reset clears valid bits and the config registers
// a one-word skid at the output lets the pipeline take a word while a result
// waits; the whole pipeline holds while the skid is full
module camera_point_projection (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [20:0] i_point_x,
    input  logic signed [20:0] i_point_y,
    input  logic signed [20:0] i_point_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [19:0] o_pixel_u,
    output logic signed [19:0] o_pixel_v,
    output logic               o_behind_camera,
    output logic               o_clipped
);

    localparam int NS = cpp_pkg::DIV_N;

    logic [47:0] r_rot [3];
    logic [62:0] r_trans;
    logic [59:0] r_intr0;
    logic [39:0] r_intr1;
    logic [63:0] r_radial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= '0;
            r_rot[1] <= '0;
            r_rot[2] <= '0;
            r_trans  <= '0;
            r_intr0  <= '0;
            r_intr1  <= '0;
            r_radial <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cpp_pkg::CFG_ROT_X:  r_rot[0] <= i_cfg_data[47:0];
                cpp_pkg::CFG_ROT_Y:  r_rot[1] <= i_cfg_data[47:0];
                cpp_pkg::CFG_ROT_Z:  r_rot[2] <= i_cfg_data[47:0];
                cpp_pkg::CFG_TRANS:  r_trans  <= i_cfg_data[62:0];
                cpp_pkg::CFG_INTR_0: r_intr0  <= i_cfg_data[59:0];
                cpp_pkg::CFG_INTR_1: r_intr1  <= i_cfg_data[39:0];
                cpp_pkg::CFG_RADIAL: r_radial <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic r_sk_full;
    assign en         = !r_sk_full;
    assign o_in_ready = en;

    // stage 1: rotation products
    logic signed [36:0] r1_m [3][3];
    logic               r1_v;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_m[i][0] <= $signed(r_rot[i][15:0])  * i_point_x;
                r1_m[i][1] <= $signed(r_rot[i][31:16]) * i_point_y;
                r1_m[i][2] <= $signed(r_rot[i][47:32]) * i_point_z;
            end
        end
    end

    // stage 2: camera coordinates
    logic signed [cpp_pkg::CAM_W-1:0] n2_cam [3];
    logic signed [cpp_pkg::CAM_W-1:0] r2_cam [3];
    logic                             r2_v;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_cam[i] = {{5{r_trans[21*i+20]}}, r_trans[21*i +: 21], 14'b0}
                      + 40'(r1_m[i][0]) + 40'(r1_m[i][1]) + 40'(r1_m[i][2]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_cam[i] <= n2_cam[i];
            end
        end
    end

    // stage 3: magnitudes, range check, divider setup
    logic [cpp_pkg::CAM_W-1:0] n3_mx, n3_my;
    cpp_pkg::t_div             n3_d;
    cpp_pkg::t_div             r3_d;
    logic                      r3_v;
    always_comb begin
        n3_mx = r2_cam[0][cpp_pkg::CAM_W-1] ? 40'(-r2_cam[0]) : r2_cam[0];
        n3_my = r2_cam[1][cpp_pkg::CAM_W-1] ? 40'(-r2_cam[1]) : r2_cam[1];
        n3_d.den    = r2_cam[2];
        n3_d.behind = (r2_cam[2] <= 0);
        n3_d.neg_x  = r2_cam[0][cpp_pkg::CAM_W-1];
        n3_d.neg_y  = r2_cam[1][cpp_pkg::CAM_W-1];
        n3_d.sat_x  = ({2'b0, n3_mx} >= {r2_cam[2], 2'b0});
        n3_d.sat_y  = ({2'b0, n3_my} >= {r2_cam[2], 2'b0});
        n3_d.rem_x  = {3'b0, n3_mx[cpp_pkg::CAM_W-1:2]};
        n3_d.rem_y  = {3'b0, n3_my[cpp_pkg::CAM_W-1:2]};
        n3_d.sh_x   = {n3_mx[1:0], 24'b0};
        n3_d.sh_y   = {n3_my[1:0], 24'b0};
        n3_d.q_x    = '0;
        n3_d.q_y    = '0;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_d <= n3_d;
        end
    end

    // divider pipeline
    cpp_pkg::t_div dv_d [NS+1];
    logic          dv_v [NS+1];
    assign dv_d[0] = r3_d;
    assign dv_v[0] = r3_v;

    for (genvar g = 0; g < NS; g++) begin : g_div
        cpp_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_d     (dv_d[g]),
            .o_valid (dv_v[g+1]),
            .o_d     (dv_d[g+1])
        );
    end

    // stage 4: normalized point
    cpp_pkg::t_div      dq;
    logic [25:0]        n4_ax, n4_ay;
    logic [25:0]        r4_ax, r4_ay;
    logic signed [26:0] r4_xn, r4_yn;
    logic               r4_clip, r4_bh, r4_v;
    assign dq    = dv_d[NS];
    assign n4_ax = dq.sat_x ? '1 : dq.q_x;
    assign n4_ay = dq.sat_y ? '1 : dq.q_y;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ax   <= n4_ax;
            r4_ay   <= n4_ay;
            r4_xn   <= dq.neg_x ? -$signed({1'b0, n4_ax}) : $signed({1'b0, n4_ax});
            r4_yn   <= dq.neg_y ? -$signed({1'b0, n4_ay}) : $signed({1'b0, n4_ay});
            r4_clip <= dq.sat_x | dq.sat_y;
            r4_bh   <= dq.behind;
        end
    end

    // stage 5: squares
    logic [51:0]        r5_sx, r5_sy;
    logic signed [26:0] r5_xn, r5_yn;
    logic               r5_clip, r5_bh, r5_v;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sx   <= r4_ax * r4_ax;
            r5_sy   <= r4_ay * r4_ay;
            r5_xn   <= r4_xn;
            r5_yn   <= r4_yn;
            r5_clip <= r4_clip;
            r5_bh   <= r4_bh;
        end
    end

    // stage 6: r^2
    logic [52:0]        n6_sum;
    logic [28:0]        r6_r2;
    logic signed [26:0] r6_xn, r6_yn;
    logic               r6_clip, r6_bh, r6_v;
    assign n6_sum = {1'b0, r5_sx} + {1'b0, r5_sy};
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_r2   <= n6_sum[52:24];
            r6_xn   <= r5_xn;
            r6_yn   <= r5_yn;
            r6_clip <= r5_clip;
            r6_bh   <= r5_bh;
        end
    end

    // stage 7: r^4 and k0 term
    logic [57:0]        n7_sq;
    logic [25:0]        r7_r4;
    logic signed [61:0] r7_p0;
    logic signed [26:0] r7_xn, r7_yn;
    logic               r7_clip, r7_bh, r7_v;
    assign n7_sq = r6_r2 * r6_r2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_r4   <= n7_sq[57:32];
            r7_p0   <= $signed(r_radial[31:0]) * $signed({1'b0, r6_r2});
            r7_xn   <= r6_xn;
            r7_yn   <= r6_yn;
            r7_clip <= r6_clip;
            r7_bh   <= r6_bh;
        end
    end

    // stage 8: k1 term
    logic signed [58:0] r8_p1;
    logic signed [37:0] r8_t0;
    logic signed [26:0] r8_xn, r8_yn;
    logic               r8_clip, r8_bh, r8_v;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_p1   <= $signed(r_radial[63:32]) * $signed({1'b0, r7_r4});
            r8_t0   <= r7_p0[61:24];
            r8_xn   <= r7_xn;
            r8_yn   <= r7_yn;
            r8_clip <= r7_clip;
            r8_bh   <= r7_bh;
        end
    end

    // stage 9: distortion factor
    logic signed [44:0] n9_d;
    logic signed [36:0] n9_ds;
    logic               n9_sat;
    logic signed [36:0] r9_d;
    logic signed [26:0] r9_xn, r9_yn;
    logic               r9_clip, r9_bh, r9_v;
    always_comb begin
        n9_d = 45'sd268435456 + 45'(r8_t0) + 45'($signed(r8_p1[58:16]));
        n9_sat = 1'b0;
        n9_ds  = n9_d[36:0];
        if (n9_d > 45'sd34359738368) begin
            n9_ds  = 37'sd34359738368;
            n9_sat = 1'b1;
        end else if (n9_d < -45'sd34359738368) begin
            n9_ds  = -37'sd34359738368;
            n9_sat = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_d    <= n9_ds;
            r9_xn   <= r8_xn;
            r9_yn   <= r8_yn;
            r9_clip <= r8_clip | n9_sat;
            r9_bh   <= r8_bh;
        end
    end

    // stage 10: distorted point
    logic signed [63:0] r10_px, r10_py;
    logic               r10_clip, r10_bh, r10_v;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_px   <= r9_xn * r9_d;
            r10_py   <= r9_yn * r9_d;
            r10_clip <= r9_clip;
            r10_bh   <= r9_bh;
        end
    end

    // stage 11: intrinsic products
    logic signed [35:0] n11_xd, n11_yd;
    logic signed [55:0] r11_fx, r11_sk, r11_fy;
    logic               r11_clip, r11_bh, r11_v;
    assign n11_xd = r10_px[63:28];
    assign n11_yd = r10_py[63:28];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_fx   <= $signed(r_intr0[19:0])  * n11_xd;
            r11_sk   <= $signed(r_intr0[39:20]) * n11_yd;
            r11_fy   <= $signed(r_intr1[19:0])  * n11_yd;
            r11_clip <= r10_clip;
            r11_bh   <= r10_bh;
        end
    end

    // stage 12: round, offset, saturate
    logic signed [56:0] n12_au, n12_av;
    logic signed [33:0] n12_pu, n12_pv;
    logic signed [19:0] n12_u, n12_v;
    logic               n12_cu, n12_cv;
    logic signed [19:0] r12_u, r12_v;
    logic               r12_bh, r12_cl, r12_vld;
    always_comb begin
        n12_au = 57'(r11_fx) + 57'(r11_sk) + 57'sd8388608;
        n12_av = 57'(r11_fy) + 57'sd8388608;
        n12_pu = 34'($signed(n12_au[56:24])) + 34'($signed(r_intr0[59:40]));
        n12_pv = 34'($signed(n12_av[56:24])) + 34'($signed(r_intr1[39:20]));
        n12_cu = 1'b1;
        n12_cv = 1'b1;
        if (n12_pu > 34'sd524287) begin
            n12_u = 20'sd524287;
        end else if (n12_pu < -34'sd524288) begin
            n12_u = -20'sd524288;
        end else begin
            n12_u  = n12_pu[19:0];
            n12_cu = 1'b0;
        end
        if (n12_pv > 34'sd524287) begin
            n12_v = 20'sd524287;
        end else if (n12_pv < -34'sd524288) begin
            n12_v = -20'sd524288;
        end else begin
            n12_v  = n12_pv[19:0];
            n12_cv = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_u  <= r11_bh ? '0 : n12_u;
            r12_v  <= r11_bh ? '0 : n12_v;
            r12_bh <= r11_bh;
            r12_cl <= !r11_bh && (r11_clip | n12_cu | n12_cv);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r10_v   <= 1'b0;
            r11_v   <= 1'b0;
            r12_vld <= 1'b0;
        end else if (en) begin
            r1_v    <= i_in_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= dv_v[NS];
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r8_v    <= r7_v;
            r9_v    <= r8_v;
            r10_v   <= r9_v;
            r11_v   <= r10_v;
            r12_vld <= r11_v;
        end
    end

    // output skid
    logic signed [19:0] r_sk_u, r_sk_v;
    logic               r_sk_bh, r_sk_cl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_full <= 1'b0;
        end else if (!r_sk_full) begin
            r_sk_full <= r12_vld && !i_out_ready;
        end else if (i_out_ready) begin
            r_sk_full <= 1'b0;
        end
        if (!r_sk_full) begin
            r_sk_u  <= r12_u;
            r_sk_v  <= r12_v;
            r_sk_bh <= r12_bh;
            r_sk_cl <= r12_cl;
        end
    end

    assign o_out_valid     = r_sk_full | r12_vld;
    assign o_pixel_u       = r_sk_full ? r_sk_u  : r12_u;
    assign o_pixel_v       = r_sk_full ? r_sk_v  : r12_v;
    assign o_behind_camera = r_sk_full ? r_sk_bh : r12_bh;
    assign o_clipped       = r_sk_full ? r_sk_cl : r12_cl;

endmodule
